/* design/pmts_pkg.sv */
// ----------------------------------------------------------------------------
// pmts_pkg
// shared types and constants of the periodic message transmit scheduler
// ----------------------------------------------------------------------------
package pmts_pkg;

	// table size and derived widths
	localparam int MAX_ENTRIES = 32;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	// fixed field widths
	localparam int COUNT_W    = 6;
	localparam int SLOT_W     = 5;
	localparam int ID_W       = 11;
	localparam int KIND_W     = 2;
	localparam int INTERVAL_W = 16;
	localparam int PHASE_W    = 3;
	localparam int CMP_W      = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	// stream widths, padded to whole bytes
	localparam int IN_W  = 40;
	localparam int OUT_W = 24;

	// entry kinds that trigger automatically, the rest never do
	localparam logic [KIND_W-1:0] KIND_CYCLIC  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ONSTART = 2'd1;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_START = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_STEP  = 2'd3
	} cmd_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE     = 3'd0,
		PH_SEND     = 3'd1,
		PH_WAIT     = 3'd2,
		PH_COMPLETE = 3'd3,
		PH_DONE     = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_EXEC,
		CS_TICK,
		CS_SCAN,
		CS_IDENT,
		CS_OUT
	} ctrl_state_t;

	typedef struct packed {
		cmd_t                  cmd;
		logic [SLOT_W-1:0]     entry_index;
		logic [ID_W-1:0]       entry_id;
		logic                  entry_enabled;
		logic [KIND_W-1:0]     entry_kind;
		logic [INTERVAL_W-1:0] entry_interval;
		logic                  link_busy;
	} item_t;

	typedef struct packed {
		logic                  send_request;
		logic [SLOT_W-1:0]     send_index;
		logic [ID_W-1:0]       send_id;
		logic [PHASE_W-1:0]    machine_state;
		logic                  picked;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic in_ready;
		logic load_item;
		logic do_write;
		logic do_start;
		logic cnt_clr;
		logic cnt_inc;
		logic tick_rd;
		logic pick;
		logic ident_latch;
		logic phase_step;
		logic load_out;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_valid;
		cmd_t cmd;
		logic phase_idle;
		logic cnt_lt_n;
		logic pend_hit;
		logic out_free;
	} ctl_stat_t;

endpackage

/* design/pmts_ctrl.sv */
// ----------------------------------------------------------------------------
// pmts_ctrl
// sequencer: runs one item at a time through exec, sweep, or scan and ident, then output
// ----------------------------------------------------------------------------
module pmts_ctrl
	import pmts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  ctl_stat_t stat,
	output ctl_cmd_t  ctl
);

	ctrl_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		ctl        = '0;
		unique case (state_q)
			CS_IDLE: begin
				ctl.in_ready = 1'b1;
				if (stat.in_valid) begin
					ctl.load_item = 1'b1;
					state_next    = CS_EXEC;
				end
			end
			CS_EXEC: begin
				unique case (stat.cmd)
					CMD_WRITE: begin
						ctl.do_write = 1'b1;
						state_next   = CS_OUT;
					end
					CMD_START: begin
						ctl.do_start = 1'b1;
						state_next   = CS_OUT;
					end
					CMD_TICK: begin
						ctl.cnt_clr = 1'b1;
						state_next  = CS_TICK;
					end
					CMD_STEP: begin
						if (stat.phase_idle) begin
							ctl.cnt_clr = 1'b1;
							state_next  = CS_SCAN;
						end else begin
							ctl.phase_step = 1'b1;
							state_next     = CS_OUT;
						end
					end
					default: state_next = CS_OUT;
				endcase
			end
			CS_TICK: begin
				// last write-back lands at the edge that leaves this state
				if (stat.cnt_lt_n) begin
					ctl.tick_rd = 1'b1;
					ctl.cnt_inc = 1'b1;
				end else begin
					state_next = CS_OUT;
				end
			end
			CS_SCAN: begin
				if (!stat.cnt_lt_n) begin
					state_next = CS_OUT;
				end else if (stat.pend_hit) begin
					ctl.pick   = 1'b1;
					state_next = CS_IDENT;
				end else begin
					ctl.cnt_inc = 1'b1;
				end
			end
			CS_IDENT: begin
				ctl.ident_latch = 1'b1;
				state_next      = CS_OUT;
			end
			CS_OUT: begin
				if (stat.out_free) begin
					ctl.load_out = 1'b1;
					state_next   = CS_IDLE;
				end
			end
			default: state_next = CS_IDLE;
		endcase
	end

endmodule

/* design/pmts_dp.sv */
// ----------------------------------------------------------------------------
// pmts_dp
// entry table, tick sweep pipeline, transmit phase and result register
// ----------------------------------------------------------------------------
module pmts_dp
	import pmts_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  ctl_cmd_t           ctl,
	output ctl_stat_t          stat,
	input  logic               in_valid,
	input  item_t              item,
	input  logic [COUNT_W-1:0] entry_count,
	output logic               out_valid,
	input  logic               out_ready,
	output result_t            result
);

	item_t                  item_q;
	logic [CNT_W-1:0]       n_active;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       cnt_idx;

	logic [ID_W-1:0]        ident_mem  [MAX_ENTRIES];
	logic [INTERVAL_W-1:0]  period_mem [MAX_ENTRIES];
	logic [INTERVAL_W-1:0]  count_mem  [MAX_ENTRIES];
	logic [KIND_W-1:0]      kind_q     [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] enable_q;
	logic [MAX_ENTRIES-1:0] pending_q;
	logic [MAX_ENTRIES-1:0] start_mask;

	logic                   wr_ok;
	logic [IDX_W-1:0]       wr_idx;

	logic                   valid_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [INTERVAL_W-1:0]  count_rd_s1;
	logic [INTERVAL_W-1:0]  period_rd_s1;
	logic [ID_W-1:0]        ident_rd_s1;

	logic                   tick_wr;
	logic                   tick_fire;
	logic [INTERVAL_W-1:0]  cd_dec;
	logic                   cd_we;
	logic [IDX_W-1:0]       cd_wa;
	logic [INTERVAL_W-1:0]  cd_wd;

	phase_t                 phase_q, phase_next;
	logic [IDX_W-1:0]       slot_q;
	logic [ID_W-1:0]        ident_q;
	logic                   req_q;
	logic                   picked_q;
	logic                   out_valid_q;
	result_t                out_q;

	// active count clipped to the table size
	always_comb begin
		if (CMP_W'(entry_count) > CMP_W'(MAX_ENTRIES)) begin
			n_active = CNT_W'(MAX_ENTRIES);
		end else begin
			n_active = CNT_W'(entry_count);
		end
	end

	assign cnt_idx = cnt_q[IDX_W-1:0];
	assign wr_ok   = CMP_W'(item_q.entry_index) < CMP_W'(MAX_ENTRIES);
	assign wr_idx  = IDX_W'(item_q.entry_index);

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.cnt_clr) begin
			cnt_q <= '0;
		end else if (ctl.cnt_inc) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// entry fields, read at the sweep index every cycle
	always_ff @(posedge clk) begin
		if (ctl.do_write && wr_ok) begin
			ident_mem[wr_idx]  <= item_q.entry_id;
			period_mem[wr_idx] <= item_q.entry_interval;
			kind_q[wr_idx]     <= item_q.entry_kind;
		end
		ident_rd_s1  <= ident_mem[cnt_idx];
		period_rd_s1 <= period_mem[cnt_idx];
	end

	// down-counters: loaded on write, updated by the tick write-back
	assign tick_wr   = valid_s1 && enable_q[idx_s1] && (kind_q[idx_s1] == KIND_CYCLIC);
	assign cd_dec    = count_rd_s1 - INTERVAL_W'(1);
	assign tick_fire = (cd_dec == '0);

	always_comb begin
		cd_we = tick_wr;
		cd_wa = idx_s1;
		cd_wd = tick_fire ? period_rd_s1 : cd_dec;
		if (ctl.do_write) begin
			cd_we = wr_ok;
			cd_wa = wr_idx;
			cd_wd = item_q.entry_interval;
		end
	end

	always_ff @(posedge clk) begin
		if (cd_we) begin
			count_mem[cd_wa] <= cd_wd;
		end
		count_rd_s1 <= count_mem[cnt_idx];
		idx_s1      <= cnt_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.tick_rd;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			start_mask[i] = enable_q[i] && (kind_q[i] == KIND_ONSTART)
				&& (CNT_W'(i) < n_active);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= '0;
			pending_q <= '0;
		end else begin
			if (ctl.do_write && wr_ok) begin
				enable_q[wr_idx]  <= item_q.entry_enabled;
				pending_q[wr_idx] <= 1'b0;
			end
			if (ctl.do_start) begin
				pending_q <= pending_q | start_mask;
			end
			if (tick_wr && tick_fire) begin
				pending_q[idx_s1] <= 1'b1;
			end
			if (ctl.pick) begin
				pending_q[cnt_idx] <= 1'b0;
			end
		end
	end

	// transmit phase
	always_comb begin
		phase_next = phase_q;
		if (ctl.pick) begin
			phase_next = PH_SEND;
		end else if (ctl.phase_step) begin
			unique case (phase_q)
				PH_SEND:     phase_next = PH_WAIT;
				PH_WAIT:     phase_next = item_q.link_busy ? PH_WAIT : PH_COMPLETE;
				PH_COMPLETE: phase_next = PH_DONE;
				default:     phase_next = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			slot_q   <= '0;
			ident_q  <= '0;
			req_q    <= 1'b0;
			picked_q <= 1'b0;
		end else begin
			phase_q <= phase_next;
			if (ctl.load_item) begin
				req_q    <= 1'b0;
				picked_q <= 1'b0;
			end
			if (ctl.phase_step && (phase_q == PH_SEND)) begin
				req_q <= 1'b1;
			end
			if (ctl.pick) begin
				picked_q <= 1'b1;
				slot_q   <= cnt_idx;
			end
			if (ctl.ident_latch) begin
				ident_q <= ident_rd_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_q.send_request  <= req_q;
			out_q.send_index    <= SLOT_W'(slot_q);
			out_q.send_id       <= ident_q;
			out_q.machine_state <= phase_q;
			out_q.picked        <= picked_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

	assign stat.in_valid   = in_valid;
	assign stat.cmd        = item_q.cmd;
	assign stat.phase_idle = (phase_q == PH_IDLE);
	assign stat.cnt_lt_n   = (cnt_q < n_active);
	assign stat.pend_hit   = pending_q[cnt_idx];
	assign stat.out_free   = !out_valid_q || out_ready;

	a_pick_to_send: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pick |=> phase_q == PH_SEND)
		else $error("pick did not move the phase to send");

	a_req_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.send_request |-> out_q.machine_state == PH_WAIT)
		else $error("send request reported outside the wait phase");

	a_picked_in_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.picked
			|-> out_q.machine_state == PH_SEND && !out_q.send_request)
		else $error("picked result not in the send phase");

	a_sweep_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> CNT_W'(idx_s1) < n_active)
		else $error("tick write-back beyond the active entries");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> !(out_valid_q && !out_ready))
		else $error("result register overwritten while stalled");

endmodule

/* design/periodic_message_tx_scheduler.sv */
// ----------------------------------------------------------------------------
// periodic_message_tx_scheduler
// transmit message table with cyclic and on-start triggers and a send machine
// ----------------------------------------------------------------------------
// sequence: write, start and non-idle step items pass exec and output; a tick
//   sweeps all n entries and an idle step scans them up to a pending one, n
//   being the active entry count, in a one-entry-per-cycle table sweep
// throughput: one item at a time, the next accepted once the result is queued
// reset: arst_n clears the phase, latched values, enable and trigger flags,
//   the count register and the result valid; no clearing pass is run
// ----------------------------------------------------------------------------
module periodic_message_tx_scheduler
	import pmts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// item stream in
	input  logic             s_tvalid,
	output logic             s_tready,
	// cmd, entry_index, entry_id, entry_enabled, entry_kind, entry_interval,
	// link_busy, zero pad
	input  logic [IN_W-1:0]  s_tdata,
	// result stream out
	output logic             m_tvalid,
	input  logic             m_tready,
	// send_request, send_index, send_id, machine_state, picked, zero pad
	output logic [OUT_W-1:0] m_tdata,
	// register port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	ctl_cmd_t           ctl;
	ctl_stat_t          stat;
	item_t              item;
	result_t            result;
	logic [COUNT_W-1:0] entry_count_q;

	// register file: entry_count at byte addresses 0 to 3, 4 to 7 read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			entry_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {{(32 - COUNT_W){1'b0}}, entry_count_q};

	// unpack the incoming item, first field in the low bits
	assign item.cmd            = cmd_t'(s_tdata[1:0]);
	assign item.entry_index    = s_tdata[6:2];
	assign item.entry_id       = s_tdata[17:7];
	assign item.entry_enabled  = s_tdata[18];
	assign item.entry_kind     = s_tdata[20:19];
	assign item.entry_interval = s_tdata[36:21];
	assign item.link_busy      = s_tdata[37];

	assign s_tready = ctl.in_ready;

	pmts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	pmts_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.in_valid    (s_tvalid),
		.item        (item),
		.entry_count (entry_count_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.result      (result)
	);

	// pack the result, first field in the low bits
	assign m_tdata = {3'b000, result.picked, result.machine_state, result.send_id,
		result.send_index, result.send_request};

endmodule
